/* rtl/kwlm_pkg.sv */
// Package with the shared types and constants of the k-way lane merge.
`default_nettype none

package kwlm_pkg;

    localparam int ID_W   = 16;
    localparam int LANE_W = 2;
    localparam int CAP_W  = 7;
    localparam int FIELD_KEY_W = 32;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_RUN  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_MERGE = 2'b10
    } state_t;

endpackage

`default_nettype wire

/* rtl/top_c_kway_lane_merge.sv */
// Load items fill up to four lane FIFOs; a run item streams them out in key order, then leftovers.
// A load is written into its lane's RAM at its transfer; a run moves to the merge state, and each result is registered.
// Loads are taken one per cycle while idle; a run emits one result per cycle while the output is not stalled,
// and holds the input stalled until its last result, or until it finds all lanes empty.
// Each lane has its own RAM bank, read at the next head address so all heads are ready each cycle.
// Reset clears lane counts and heads and sets order_by_time; RAM contents stay undefined.
`default_nettype none

module top_c_kway_lane_merge #(
    parameter int LANES      = 4,
    parameter int LANE_DEPTH = 16,
    parameter int KEY_BITS   = 32
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_wr_en,
    input  wire logic                             cfg_wr_data,
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic                             op,
    input  wire logic [kwlm_pkg::LANE_W-1:0]      lane,
    input  wire logic [kwlm_pkg::FIELD_KEY_W-1:0] distance_key,
    input  wire logic [kwlm_pkg::FIELD_KEY_W-1:0] time_key,
    input  wire logic [kwlm_pkg::ID_W-1:0]        entry_id,
    input  wire logic [kwlm_pkg::CAP_W-1:0]       capacity,
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic      [kwlm_pkg::ID_W-1:0]        out_id,
    output logic      [kwlm_pkg::LANE_W-1:0]      out_lane,
    output logic                                  by_key,
    output logic                                  last
);

    localparam int KW = (KEY_BITS < kwlm_pkg::FIELD_KEY_W) ? KEY_BITS : kwlm_pkg::FIELD_KEY_W;
    localparam int WW = kwlm_pkg::ID_W + 2 * KW;
    localparam int AW = (LANE_DEPTH > 1) ? $clog2(LANE_DEPTH) : 1;
    localparam int CW = $clog2(LANE_DEPTH + 1);

    kwlm_pkg::state_t state_reg, state_next;
    logic order_by_time_reg;
    logic [CW-1:0] count_reg [LANES];
    logic [CW-1:0] count_next [LANES];
    logic [CW-1:0] head_reg [LANES];
    logic [CW-1:0] head_next [LANES];
    logic [kwlm_pkg::CAP_W-1:0] picks_reg, picks_next;

    logic out_valid_reg, out_valid_next;
    logic [kwlm_pkg::ID_W-1:0] out_id_reg;
    logic [kwlm_pkg::LANE_W-1:0] out_lane_reg;
    logic by_key_reg;
    logic last_reg;

    logic in_xfer;
    logic [LANES-1:0] lane_we;
    logic [LANES-1:0] nonempty;
    logic [LANES-1:0] head_ok;
    logic [WW-1:0] wr_word;
    logic [WW-1:0] rd_word [LANES];

    logic use_key;
    logic found;
    logic [KW-1:0] best_key;
    logic [KW-1:0] cand_key;
    logic [LANES-1:0] pick_oh;
    logic [kwlm_pkg::ID_W-1:0] best_id;
    logic [kwlm_pkg::LANE_W-1:0] best_lane;
    logic cand_last;
    logic out_free;
    logic adv;
    logic run_end;

    assign in_stall = (state_reg != kwlm_pkg::ST_IDLE);
    assign in_xfer  = in_valid && !in_stall;
    assign wr_word  = {entry_id, time_key[KW-1:0], distance_key[KW-1:0]};

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            lane_we[l] = in_xfer && (op == kwlm_pkg::OP_LOAD) && (32'(lane) == l)
                         && (32'(count_reg[l]) < LANE_DEPTH);
            nonempty[l] = (head_reg[l] < count_reg[l]);
            head_ok[l]  = (head_reg[l] <= count_reg[l]);
        end
    end

    for (genvar g = 0; g < LANES; g++)
    begin : g_lane
        kwlm_ram #(
            .WIDTH (WW),
            .DEPTH (LANE_DEPTH)
        ) u_ram (
            .clk   (clk),
            .we    (lane_we[g]),
            .waddr (count_reg[g][AW-1:0]),
            .wdata (wr_word),
            .raddr (head_next[g][AW-1:0]),
            .rdata (rd_word[g])
        );
    end

    // Key phase picks the smallest head, lowest lane on ties; leftover phase takes the first non-empty lane.
    always_comb
    begin
        use_key   = (picks_reg != '0);
        found     = 1'b0;
        best_key  = '0;
        cand_key  = '0;
        pick_oh   = '0;
        best_id   = '0;
        best_lane = '0;
        cand_last = 1'b1;
        for (int l = 0; l < LANES; l++)
        begin
            cand_key = order_by_time_reg ? rd_word[l][2*KW-1:KW] : rd_word[l][KW-1:0];
            if (nonempty[l] && (!found || (use_key && (cand_key < best_key))))
            begin
                found     = 1'b1;
                best_key  = cand_key;
                pick_oh   = '0;
                pick_oh[l] = 1'b1;
                best_id   = rd_word[l][WW-1:2*KW];
                best_lane = kwlm_pkg::LANE_W'(l);
            end
        end
        for (int l = 0; l < LANES; l++)
        begin
            if ((head_reg[l] + CW'(pick_oh[l])) != count_reg[l])
            begin
                cand_last = 1'b0;
            end
        end
    end

    assign out_free = !out_valid_reg || !out_stall;
    assign adv      = (state_reg == kwlm_pkg::ST_MERGE) && found && out_free;
    assign run_end  = (state_reg == kwlm_pkg::ST_MERGE) && (!found || (adv && cand_last));

    always_comb
    begin
        state_next = state_reg;
        picks_next = picks_reg;
        for (int l = 0; l < LANES; l++)
        begin
            count_next[l] = count_reg[l];
            head_next[l]  = head_reg[l];
        end
        unique case (state_reg)
            kwlm_pkg::ST_IDLE:
            begin
                for (int l = 0; l < LANES; l++)
                begin
                    if (lane_we[l])
                    begin
                        count_next[l] = count_reg[l] + CW'(1);
                    end
                end
                if (in_xfer && (op == kwlm_pkg::OP_RUN))
                begin
                    picks_next = capacity;
                    state_next = kwlm_pkg::ST_MERGE;
                end
            end
            kwlm_pkg::ST_MERGE:
            begin
                if (adv)
                begin
                    for (int l = 0; l < LANES; l++)
                    begin
                        head_next[l] = head_reg[l] + CW'(pick_oh[l]);
                    end
                    if (use_key)
                    begin
                        picks_next = picks_reg - kwlm_pkg::CAP_W'(1);
                    end
                end
                if (run_end)
                begin
                    for (int l = 0; l < LANES; l++)
                    begin
                        count_next[l] = '0;
                        head_next[l]  = '0;
                    end
                    state_next = kwlm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = kwlm_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= kwlm_pkg::ST_IDLE;
            order_by_time_reg <= 1'b1;
            picks_reg         <= '0;
            out_valid_reg     <= 1'b0;
            for (int l = 0; l < LANES; l++)
            begin
                count_reg[l] <= '0;
                head_reg[l]  <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            picks_reg     <= picks_next;
            out_valid_reg <= out_valid_next;
            for (int l = 0; l < LANES; l++)
            begin
                count_reg[l] <= count_next[l];
                head_reg[l]  <= head_next[l];
            end
            if (cfg_wr_en)
            begin
                order_by_time_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_id_reg   <= best_id;
            out_lane_reg <= best_lane;
            by_key_reg   <= use_key;
            last_reg     <= cand_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_id    = out_id_reg;
    assign out_lane  = out_lane_reg;
    assign by_key    = by_key_reg;
    assign last      = last_reg;

`ifndef ASSERT_OFF
    // A transfer out of the merge takes exactly one lane, and that lane holds an entry.
    assert property (@(posedge clk) disable iff (!rst_n)
        adv |-> ($onehot(pick_oh) && ((pick_oh & ~nonempty) == '0)))
    else $error("merge picked an empty lane or several lanes");

    // No head pointer ever runs past the fill count of its lane.
    assert property (@(posedge clk) disable iff (!rst_n)
        &head_ok)
    else $error("lane head passed lane count");

    // Once the key phase is over, it does not start again within the same run.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == kwlm_pkg::ST_MERGE && picks_reg == '0) |=> (picks_reg == '0))
    else $error("key picks resumed after leftover phase");

    // The transfer marked last ends the run and returns the block to idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (adv && cand_last) |=> (state_reg == kwlm_pkg::ST_IDLE && !$past(in_xfer)))
    else $error("run did not end after its last result");
`endif

endmodule

`default_nettype wire

/* rtl/kwlm_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
`default_nettype none

module kwlm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire
